FILE: hw/rtl/calendar_date_arithmetic_core_assert.svh
// Assertion macros for the date arithmetic core
`ifndef CALENDAR_DATE_ARITHMETIC_CORE_ASSERT_SVH
`define CALENDAR_DATE_ARITHMETIC_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CDA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CDA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CDA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/cda_pkg.sv
package cda_pkg;
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_CMP = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;
   localparam logic [21:0] MAX_DAYNUM = 22'd3652058;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [22:0] n1;
      logic signed [22:0] n2;
      logic signed [21:0] off;
   } job_type;

   function automatic logic [8:0] cum_days(input logic [3:0] m);
      logic [8:0] r;
      begin
         case (m)
            4'd1: r = 9'd0;
            4'd2: r = 9'd31;
            4'd3: r = 9'd59;
            4'd4: r = 9'd90;
            4'd5: r = 9'd120;
            4'd6: r = 9'd151;
            4'd7: r = 9'd181;
            4'd8: r = 9'd212;
            4'd9: r = 9'd243;
            4'd10: r = 9'd273;
            4'd11: r = 9'd304;
            default: r = 9'd334;
         endcase
         return r;
      end
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] r;
      begin
         case (m)
            4'd2: r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default: r = 5'd31;
         endcase
         return r;
      end
   endfunction

   // y/4 divisible by 25 via the inverse of 25 mod 4096 (valid for y/4 < 4096)
   function automatic logic leap_year(input logic [13:0] y);
      logic [23:0] prod;
      logic        div25;
      begin
         prod = 24'(y[13:2]) * 24'd3113;
         div25 = (prod[11:0] <= 12'd163);
         return (y[1:0] == 2'd0) && (!div25 || y[3:0] == 4'd0);
      end
   endfunction
endpackage

FILE: hw/rtl/cda_front.sv
// Front: clamps year and month, turns the date (both dates for compare) into a day
// number; loops over years by 400/100/4/1 strides (subtract-based), one stride per cycle.
module cda_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_operation,
   input  logic [13:0]       req_year,
   input  logic [3:0]        req_month,
   input  logic [4:0]        req_day,
   input  logic [20:0]       req_offset_days,
   input  logic [13:0]       req_other_year,
   input  logic [3:0]        req_other_month,
   input  logic [4:0]        req_other_day,
   output logic              job_valid,
   output cda_pkg::job_type  job,
   input  logic              job_ready
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CONV = 3'd1;
   localparam logic [2:0] S_PUSH = 3'd2;

   logic [2:0] state_ff, state_in;
   logic       sel_ff, sel_in;
   logic [13:0] p_ff, p_in;
   logic [22:0] acc_ff, acc_in;
   logic [13:0] y2_ff, y2_in;
   logic [3:0]  m2_ff, m2_in;
   logic [4:0]  d2_ff, d2_in;
   cda_pkg::job_type job_ff, job_in;

   function automatic logic [13:0] cy(input logic [13:0] y);
      return (y == 14'd0) ? 14'd1 : ((y > 14'd9999) ? 14'd9999 : y);
   endfunction
   function automatic logic [3:0] cm(input logic [3:0] m);
      return (m == 4'd0) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);
   endfunction
   function automatic logic [22:0] base(input logic [13:0] y, input logic [3:0] m,
                                        input logic [4:0] d);
      logic [13:0] yy;
      logic [3:0]  mm;
      logic        lp;
      begin
         yy = cy(y);
         mm = cm(m);
         lp = cda_pkg::leap_year(yy);
         return 23'(cda_pkg::cum_days(mm)) + 23'((mm > 4'd2 && lp) ? 1 : 0)
                + 23'(d) - 23'd1;
      end
   endfunction

   logic [22:0] step;
   logic [13:0] dec;
   always_comb begin
      if (p_ff >= 14'd400) begin
         step = 23'd146097; dec = 14'd400;
      end else if (p_ff >= 14'd100) begin
         step = 23'd36524; dec = 14'd100;
      end else if (p_ff >= 14'd4) begin
         step = 23'd1461; dec = 14'd4;
      end else begin
         step = 23'd365; dec = 14'd1;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign job_valid = (state_ff == S_PUSH);
   assign job = job_ff;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      p_in = p_ff;
      acc_in = acc_ff;
      y2_in = y2_ff;
      m2_in = m2_ff;
      d2_in = d2_ff;
      job_in = job_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               job_in.op = req_operation;
               job_in.off = 22'(signed'(req_offset_days));
               job_in.n2 = '0;
               p_in = cy(req_year) - 14'd1;
               acc_in = base(req_year, req_month, req_day);
               y2_in = req_other_year;
               m2_in = req_other_month;
               d2_in = req_other_day;
               sel_in = 1'b0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (p_ff == 14'd0) begin
               if (!sel_ff) begin
                  job_in.n1 = signed'(acc_ff);
                  if (job_ff.op == cda_pkg::OP_CMP) begin
                     sel_in = 1'b1;
                     p_in = cy(y2_ff) - 14'd1;
                     acc_in = base(y2_ff, m2_ff, d2_ff);
                  end else begin
                     state_in = S_PUSH;
                  end
               end else begin
                  job_in.n2 = signed'(acc_ff);
                  state_in = S_PUSH;
               end
            end else begin
               p_in = p_ff - dec;
               acc_in = acc_ff + step;
            end
         end
         S_PUSH: begin
            if (job_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sel_ff <= sel_in;
      p_ff <= p_in;
      acc_ff <= acc_in;
      y2_ff <= y2_in;
      m2_ff <= m2_in;
      d2_ff <= d2_in;
      job_ff <= job_in;
   end
endmodule

FILE: hw/rtl/cda_queue.sv
// Two-entry job queue between front and back
module cda_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cda_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output cda_pkg::job_type out_job
);
   cda_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_job;
   end
endmodule

FILE: hw/rtl/cda_back.sv
// Back: applies the operation and, for add or subtract, turns the day number back into
// a date, one year stride or one month per cycle.
module cda_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  cda_pkg::job_type  job,
   output logic              rsp_valid,
   output logic [13:0]       rsp_result_year,
   output logic [3:0]        rsp_result_month,
   output logic [4:0]        rsp_result_day,
   output logic [22:0]       rsp_day_difference,
   output logic              rsp_is_less,
   output logic              rsp_is_equal,
   output logic              rsp_range_error,
   output logic              idle
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CLIP = 3'd1;
   localparam logic [2:0] S_YEAR = 3'd2;
   localparam logic [2:0] S_MON  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic signed [23:0] t_ff, t_in;
   logic [21:0] r_ff, r_in;
   logic [13:0] y_ff, y_in;
   logic [3:0]  m_ff, m_in;
   logic [1:0]  c100_ff, c100_in;
   logic [1:0]  c1_ff, c1_in;
   logic        err_ff, err_in;
   logic [1:0]  op_ff, op_in;
   logic [22:0] diff_ff, diff_in;
   logic        lt_ff, lt_in, eq_ff, eq_in;
   logic        vout_ff, vout_in;

   logic leap;
   logic [4:0] mlen;
   assign leap = cda_pkg::leap_year(y_ff);
   assign mlen = cda_pkg::month_len(m_ff, leap);

   assign job_ready = (state_ff == S_IDLE);
   assign idle = (state_ff == S_IDLE) && !job_valid;

   always_comb begin
      state_in = state_ff;
      t_in = t_ff; r_in = r_ff; y_in = y_ff; m_in = m_ff;
      c100_in = c100_ff; c1_in = c1_ff; err_in = err_ff; op_in = op_ff;
      diff_in = diff_ff; lt_in = lt_ff; eq_in = eq_ff;
      vout_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               op_in = job.op;
               err_in = 1'b0;
               diff_in = 23'(job.n1 - job.n2);
               lt_in = job.n1 < job.n2;
               eq_in = job.n1 == job.n2;
               t_in = (job.op == cda_pkg::OP_ADD) ? 24'(job.n1) + 24'(job.off)
                                                  : 24'(job.n1) - 24'(job.off);
               if (job.op == cda_pkg::OP_ADD || job.op == cda_pkg::OP_SUB)
                  state_in = S_CLIP;
               else
                  state_in = S_OUT;
            end
         end
         S_CLIP: begin
            if (t_ff < 0) begin
               r_in = '0; err_in = 1'b1;
            end else if (t_ff > signed'({2'b00, cda_pkg::MAX_DAYNUM})) begin
               r_in = cda_pkg::MAX_DAYNUM; err_in = 1'b1;
            end else begin
               r_in = t_ff[21:0];
            end
            y_in = 14'd1; m_in = 4'd1; c100_in = '0; c1_in = '0;
            state_in = S_YEAR;
         end
         S_YEAR: begin
            if (r_ff >= 22'd146097) begin
               r_in = r_ff - 22'd146097; y_in = y_ff + 14'd400;
            end else if (r_ff >= 22'd36524 && c100_ff != 2'd3) begin
               r_in = r_ff - 22'd36524; y_in = y_ff + 14'd100; c100_in = c100_ff + 2'd1;
            end else if (r_ff >= 22'd1461) begin
               r_in = r_ff - 22'd1461; y_in = y_ff + 14'd4;
            end else if (r_ff >= 22'd365 && c1_ff != 2'd3) begin
               r_in = r_ff - 22'd365; y_in = y_ff + 14'd1; c1_in = c1_ff + 2'd1;
            end else begin
               state_in = S_MON;
            end
         end
         S_MON: begin
            if (m_ff != 4'd12 && r_ff >= 22'(mlen)) begin
               r_in = r_ff - 22'(mlen); m_in = m_ff + 4'd1;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            vout_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   logic arith, cmp;
   assign arith = (op_ff == cda_pkg::OP_ADD) || (op_ff == cda_pkg::OP_SUB);
   assign cmp = (op_ff == cda_pkg::OP_CMP);
   assign rsp_valid = vout_ff;
   assign rsp_result_year = arith ? y_ff : '0;
   assign rsp_result_month = arith ? m_ff : '0;
   assign rsp_result_day = arith ? 5'(r_ff) + 5'd1 : '0;
   assign rsp_range_error = arith & err_ff;
   assign rsp_day_difference = cmp ? diff_ff : '0;
   assign rsp_is_less = cmp & lt_ff;
   assign rsp_is_equal = cmp & eq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vout_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vout_ff <= vout_in;
      end
      t_ff <= t_in; r_ff <= r_in; y_ff <= y_in; m_ff <= m_in;
      c100_ff <= c100_in; c1_ff <= c1_in; err_ff <= err_in; op_ff <= op_in;
      diff_ff <= diff_in; lt_ff <= lt_in; eq_ff <= eq_in;
   end
endmodule

FILE: hw/rtl/calendar_date_arithmetic_core.sv
// Flow: the front converts the date to a day number, one year stride per cycle (both dates
// for compare), and hands the job through a two-entry queue to the back, which takes year
// strides and then months; a result waits for earlier items still in the back.
// The front takes a new request once it has handed its job to the queue, so requests can
// overlap work in the back. Result strobe lasts one cycle; the receiver cannot stall.
// Synchronous active-high reset clears all control state.
`include "calendar_date_arithmetic_core_assert.svh"
module calendar_date_arithmetic_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [13:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic signed [20:0] req_offset_days,
   input  logic [13:0] req_other_year,
   input  logic [3:0]  req_other_month,
   input  logic [4:0]  req_other_day,
   output logic        rsp_valid,
   output logic [13:0] rsp_result_year,
   output logic [3:0]  rsp_result_month,
   output logic [4:0]  rsp_result_day,
   output logic signed [22:0] rsp_day_difference,
   output logic        rsp_is_less,
   output logic        rsp_is_equal,
   output logic        rsp_range_error
);
   logic f_valid, f_ready, b_valid, b_ready, b_idle;
   cda_pkg::job_type f_job, b_job;
   logic [22:0] diff_raw;

   cda_front u_front (
      .clock, .reset, .start, .busy,
      .req_operation, .req_year, .req_month, .req_day,
      .req_offset_days(req_offset_days),
      .req_other_year, .req_other_month, .req_other_day,
      .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
   );

   cda_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
   );

   cda_back u_back (
      .clock, .reset,
      .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .rsp_valid, .rsp_result_year, .rsp_result_month, .rsp_result_day,
      .rsp_day_difference(diff_raw), .rsp_is_less, .rsp_is_equal,
      .rsp_range_error, .idle(b_idle)
   );
   assign rsp_day_difference = signed'(diff_raw);

   `CDA_ASSERT_IMPL(a_lt_eq_excl, clock, reset, rsp_valid, !(rsp_is_less && rsp_is_equal))
   `CDA_ASSERT_IMPL(a_eq_zero, clock, reset, rsp_valid && rsp_is_equal, rsp_day_difference == 23'sd0)
   `CDA_ASSERT_NEXT(a_strobe_one, clock, reset, rsp_valid, !rsp_valid)
   `CDA_ASSERT_NEXT(a_idle_quiet, clock, reset, b_idle, !rsp_valid)
endmodule

FILE: bench/calendar_date_arithmetic_core_tb.sv
`timescale 1ns / 1ps
module calendar_date_arithmetic_core_tb;

   typedef struct {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic signed [22:0] diff;
      logic        less;
      logic        equal;
      logic        rerr;
   } date_result_type;

   class date_scoreboard;
      date_result_type pending[$];
      int errors;
      int checked;

      function bit leap(int y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      function int day_number(logic [13:0] yi, logic [3:0] mi, logic [4:0] di);
         int y, m, p, n;
         int cum[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
         y = yi;
         m = mi;
         if (y < 1) y = 1;
         if (y > 9999) y = 9999;
         if (m < 1) m = 1;
         if (m > 12) m = 12;
         p = y - 1;
         n = p * 365 + p / 4 - p / 100 + p / 400 + cum[m - 1];
         if (m > 2 && leap(y)) n++;
         return n + int'(di) - 1;
      endfunction

      function void to_date(int n, output int y, output int m, output int d);
         int q400, q100, q4, q1, r, mo, len;
         int mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
         q400 = n / 146097;
         r = n % 146097;
         q100 = r / 36524;
         if (q100 > 3) q100 = 3;
         r -= q100 * 36524;
         q4 = r / 1461;
         r -= q4 * 1461;
         q1 = r / 365;
         if (q1 > 3) q1 = 3;
         r -= q1 * 365;
         y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
         for (mo = 0; mo < 11; mo++) begin
            len = mlen[mo] + ((mo == 1 && leap(y)) ? 1 : 0);
            if (r < len) break;
            r -= len;
         end
         m = mo + 1;
         d = r + 1;
      endfunction

      function void note_request(logic [1:0] op, logic [13:0] y, logic [3:0] m,
                                 logic [4:0] d, logic signed [20:0] off,
                                 logic [13:0] oy, logic [3:0] om,
                                 logic [4:0] od);
         date_result_type e;
         int n1, n2, t, ry, rm, rd;
         e = '{default: '0};
         n1 = day_number(y, m, d);
         if (op == cda_pkg::OP_ADD || op == cda_pkg::OP_SUB) begin
            t = (op == cda_pkg::OP_ADD) ? n1 + int'(off) : n1 - int'(off);
            if (t < 0) begin
               t = 0;
               e.rerr = 1;
            end else if (t > int'(cda_pkg::MAX_DAYNUM)) begin
               t = int'(cda_pkg::MAX_DAYNUM);
               e.rerr = 1;
            end
            to_date(t, ry, rm, rd);
            e.year = 14'(ry);
            e.month = 4'(rm);
            e.day = 5'(rd);
         end else if (op == cda_pkg::OP_CMP) begin
            n2 = day_number(oy, om, od);
            e.diff = 23'(n1 - n2);
            e.less = n1 < n2;
            e.equal = n1 == n2;
         end
         pending.push_back(e);
      endfunction

      function void check_result(date_result_type a);
         date_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result y=%0d m=%0d d=%0d", $realtime, a.year, a.month,
                     a.day);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.year !== e.year || a.month !== e.month || a.day !== e.day ||
             a.diff !== e.diff || a.less !== e.less || a.equal !== e.equal ||
             a.rerr !== e.rerr) begin
            $display("%0t: mismatch expected %0d-%0d-%0d diff=%0d lt=%0b eq=%0b err=%0b",
                     $realtime, e.year, e.month, e.day, e.diff, e.less, e.equal, e.rerr);
            $display("%0t:          actual   %0d-%0d-%0d diff=%0d lt=%0b eq=%0b err=%0b",
                     $realtime, a.year, a.month, a.day, a.diff, a.less, a.equal, a.rerr);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid;
   logic [1:0] req_operation = '0;
   logic [13:0] req_year = '0, req_other_year = '0;
   logic [3:0] req_month = '0, req_other_month = '0;
   logic [4:0] req_day = '0, req_other_day = '0;
   logic signed [20:0] req_offset_days = '0;
   logic [13:0] rsp_result_year;
   logic [3:0] rsp_result_month;
   logic [4:0] rsp_result_day;
   logic signed [22:0] rsp_day_difference;
   logic rsp_is_less, rsp_is_equal, rsp_range_error;

   date_scoreboard sb = new();
   int cycles = 0;
   int ops_seen[4];

   calendar_date_arithmetic_core dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      date_result_type a;
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("calendar_date_arithmetic_core_tb: FAIL");
         $finish;
      end
      if (!reset && rsp_valid) begin
         a.year = rsp_result_year;
         a.month = rsp_result_month;
         a.day = rsp_result_day;
         a.diff = rsp_day_difference;
         a.less = rsp_is_less;
         a.equal = rsp_is_equal;
         a.rerr = rsp_range_error;
         sb.check_result(a);
      end
   end

   task automatic send(logic [1:0] op, logic [13:0] y, logic [3:0] m, logic [4:0] d,
                       logic signed [20:0] off, logic [13:0] oy, logic [3:0] om,
                       logic [4:0] od, int gap);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= op;
      req_year <= y;
      req_month <= m;
      req_day <= d;
      req_offset_days <= off;
      req_other_year <= oy;
      req_other_month <= om;
      req_other_day <= od;
      start <= 1;
      do @(posedge clock); while (busy);
      sb.note_request(op, y, m, d, off, oy, om, od);
      ops_seen[op]++;
   endtask

   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [13:0] pick_year();
      int r = $urandom_range(0, 9);
      if (r == 0) return 14'($urandom);
      if (r == 1) return $urandom_range(0, 3) ? 14'($urandom_range(1, 5)) : 14'd0;
      if (r == 2) return 14'($urandom_range(9995, 9999));
      return 14'($urandom_range(1, 9999));
   endfunction

   function automatic logic [3:0] pick_month();
      return $urandom_range(0, 7) ? 4'($urandom_range(1, 12)) : 4'($urandom);
   endfunction

   function automatic logic [4:0] pick_day();
      return $urandom_range(0, 7) ? 5'($urandom_range(1, 28)) : 5'($urandom);
   endfunction

   function automatic logic signed [20:0] pick_offset();
      int r = $urandom_range(0, 3);
      if (r == 0) return 21'($urandom);
      if (r == 1) return 21'($signed(21'($urandom_range(0, 800))) - 400);
      return 21'($signed(21'($urandom_range(0, 80000))) - 40000);
   endfunction

   initial begin
      int burst;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(cda_pkg::OP_ADD, 1, 1, 1, 0, 1, 1, 1, 0);
      send(cda_pkg::OP_ADD, 9999, 12, 31, 1, 1, 1, 1, 0);
      send(cda_pkg::OP_SUB, 1, 1, 1, 1, 1, 1, 1, 0);
      send(cda_pkg::OP_ADD, 1, 1, 1, 21'sh0FFFFF, 1, 1, 1, 1);
      send(cda_pkg::OP_ADD, 9999, 12, 31, 21'sh100000, 1, 1, 1, 0);
      send(cda_pkg::OP_SUB, 5000, 6, 15, 21'sh100001, 1, 1, 1, 0);
      send(cda_pkg::OP_ADD, 2000, 2, 28, 1, 1, 1, 1, 0);
      send(cda_pkg::OP_ADD, 1900, 2, 28, 1, 1, 1, 1, 2);
      send(cda_pkg::OP_SUB, 2024, 3, 1, -1, 1, 1, 1, 0);
      send(cda_pkg::OP_ADD, 0, 0, 0, 0, 1, 1, 1, 0);
      send(cda_pkg::OP_ADD, 14'h3FFF, 4'hF, 5'h1F, 0, 1, 1, 1, 0);
      send(cda_pkg::OP_ADD, 2023, 2, 31, 0, 1, 1, 1, 0);
      send(cda_pkg::OP_CMP, 1, 1, 1, 0, 9999, 12, 31, 0);
      send(cda_pkg::OP_CMP, 9999, 12, 31, 0, 1, 1, 1, 0);
      send(cda_pkg::OP_CMP, 2020, 5, 5, 0, 2020, 5, 5, 0);
      send(cda_pkg::OP_CMP, 2021, 3, 0, 0, 2021, 2, 28, 3);
      send(cda_pkg::OP_CMP, 0, 13, 31, 0, 14'h3FFF, 0, 0, 0);
      send(cda_pkg::OP_NOP, 1234, 5, 6, 77, 2000, 1, 1, 0);
      send(cda_pkg::OP_NOP, 14'h3FFF, 4'hF, 5'h1F, -1, 14'h3FFF, 4'hF, 5'h1F, 0);
      for (int i = 0; i < 1500; i++) begin
         int r;
         logic [13:0] y;
         logic [3:0] m;
         logic [4:0] d;
         burst = ($urandom_range(0, 9) == 0);
         r = $urandom_range(0, 99);
         y = pick_year();
         m = pick_month();
         d = pick_day();
         if (r < 35)
            send(cda_pkg::OP_ADD, y, m, d, pick_offset(), 0, 0, 0, burst ? 0 : pick_gap());
         else if (r < 70)
            send(cda_pkg::OP_SUB, y, m, d, pick_offset(), 0, 0, 0, burst ? 0 : pick_gap());
         else if (r < 95) begin
            if ($urandom_range(0, 3) == 0)
               send(cda_pkg::OP_CMP, y, m, d, 21'($urandom), y, m,
                    5'(d + 5'($urandom_range(0, 1))), pick_gap());
            else
               send(cda_pkg::OP_CMP, y, m, d, 21'($urandom), pick_year(), pick_month(),
                    pick_day(), burst ? 0 : pick_gap());
         end else
            send(cda_pkg::OP_NOP, y, m, d, 21'($urandom), 14'($urandom), 4'($urandom),
                 5'($urandom), pick_gap());
      end
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("Checked %0d results: add %0d, subtract %0d, compare %0d, unused %0d.",
               sb.checked, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3]);
      if (sb.errors == 0)
         $display("calendar_date_arithmetic_core_tb: PASS");
      else
         $display("calendar_date_arithmetic_core_tb: FAIL");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/cda_pkg.sv
hw/rtl/cda_front.sv
hw/rtl/cda_queue.sv
hw/rtl/cda_back.sv
hw/rtl/calendar_date_arithmetic_core.sv
bench/calendar_date_arithmetic_core_tb.sv
